// ----- src/assert_macros.svh -----
// assertion macros shared by the flash sector mapper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define FSMAP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fsmap property violated");

// condition that must never be seen on a rising edge outside reset
`define FSMAP_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fsmap forbidden condition seen");

`endif

// ----- src/fsmap_pkg.sv -----
// types, constants and register map of the flash sector mapper
`timescale 1ns / 1ps
`default_nettype none

package fsmap_pkg;

    // region table
    localparam int REGION_REGS  = 4;
    localparam int REGIONS      = 4;
    localparam int LIVE_REGIONS = (REGIONS < REGION_REGS) ? REGIONS : REGION_REGS;
    localparam int REG_IDX_W    = $clog2(REGION_REGS);
    localparam logic [REG_IDX_W-1:0] LAST_REGION = REG_IDX_W'(LIVE_REGIONS - 1);

    // field widths
    localparam int CNT_W    = 8;
    localparam int SIZE_W   = 16;
    localparam int REGION_W = CNT_W + SIZE_W;
    localparam int ADDR_W   = 32;
    localparam int ANS_W    = 32;
    localparam int OP_W     = 2;
    localparam int FIRST_W  = 8;
    localparam int SCALE_W  = 5;

    // datapath widths
    localparam int KB_SHIFT  = 10;
    localparam int KB_W      = ADDR_W - KB_SHIFT;
    localparam int RK_W      = KB_W + 1;
    localparam int SPAN_W    = CNT_W + SIZE_W;
    localparam int QUO_W     = CNT_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int IDX_W     = CNT_W + $clog2(LIVE_REGIONS + 2);
    localparam int SCALED_W  = IDX_W + SCALE_W;

    // stream payload layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = PADDR_W - 2;
    localparam logic [RIDX_W-1:0] REG_BASE  = 3'd4;
    localparam logic [RIDX_W-1:0] REG_FIRST = 3'd5;
    localparam logic [RIDX_W-1:0] REG_SCALE = 3'd6;

    // reset values: 4 x 16 KB, 1 x 64 KB, 7 x 128 KB, terminator
    localparam logic [REGION_REGS-1:0][REGION_W-1:0] REGION_RESET =
        {24'd0, 24'd32775, 24'd16385, 24'd4100};
    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'h0800_0000;
    localparam logic [FIRST_W-1:0] FIRST_RESET = 8'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd1;

    // query codes
    typedef enum logic [OP_W-1:0] {
        OP_ADDR  = 2'd0,
        OP_SIZE  = 2'd1,
        OP_START = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef struct packed {
        logic [REGION_REGS-1:0][REGION_W-1:0] region;
        logic [ADDR_W-1:0]                    base;
        logic [FIRST_W-1:0]                   first_index;
        logic [SCALE_W-1:0]                   scale;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic walk;
        logic div_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_stop;
        logic walk_div;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- src/fsmap_regs.sv -----
// configuration register file with its register-bus port
`timescale 1ns / 1ps
`default_nettype none

module fsmap_regs
    import fsmap_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              wr_en;
    logic [RIDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            priority if (reg_idx < RIDX_W'(REGION_REGS))
                cfg_next.region[reg_idx[REG_IDX_W-1:0]] = pwdata[REGION_W-1:0];
            else if (reg_idx == REG_BASE)
                cfg_next.base = pwdata[ADDR_W-1:0];
            else if (reg_idx == REG_FIRST)
                cfg_next.first_index = pwdata[FIRST_W-1:0];
            else if (reg_idx == REG_SCALE)
                cfg_next.scale = pwdata[SCALE_W-1:0];
            else
                cfg_next = cfg_reg;
        end
    end

    // read mux
    always_comb
    begin
        priority if (reg_idx < RIDX_W'(REGION_REGS))
            prdata = PDATA_W'(cfg_reg.region[reg_idx[REG_IDX_W-1:0]]);
        else if (reg_idx == REG_BASE)
            prdata = PDATA_W'(cfg_reg.base);
        else if (reg_idx == REG_FIRST)
            prdata = PDATA_W'(cfg_reg.first_index);
        else if (reg_idx == REG_SCALE)
            prdata = PDATA_W'(cfg_reg.scale);
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region      <= REGION_RESET;
            cfg_reg.base        <= BASE_RESET;
            cfg_reg.first_index <= FIRST_RESET;
            cfg_reg.scale       <= SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/fsmap_ctrl.sv -----
// query sequencer: accept, region walk, shared divide, result hand-off
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fsmap_ctrl
    import fsmap_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              div_last;

    // commands
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.start    = s_tvalid && s_tready;
    assign cmd.walk     = (state_reg == ST_WALK);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.load_out = (state_reg == ST_FIN) && status.out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                priority if (status.walk_stop)
                    state_next = ST_FIN;
                else if (status.walk_div)
                    state_next = ST_DIV;
                else
                    state_next = ST_WALK;
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // divide step counter
    always_comb
    begin
        if (state_reg == ST_DIV)
            step_next = step_reg + 1'b1;
        else
            step_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // last divide step
    assign div_last = (state_reg == ST_DIV) && (step_reg == LAST_STEP);

    // step counter only runs during a divide
    `FSMAP_NEVER(a_step_idle, clk, rst_n, (state_reg != ST_DIV) && (step_reg != '0))

    // a divide always ends in the result state after its last step
    `FSMAP_ASSERT(a_div_to_fin, clk, rst_n, div_last |=> (state_reg == ST_FIN))

endmodule

`default_nettype wire

// ----- src/fsmap_dp.sv -----
// region walker, shared restoring divider, result forming and output register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fsmap_dp
    import fsmap_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire cfg_t           cfg,
    input  wire cmd_t           cmd,
    output status_t             status,
    input  wire  [OP_W-1:0]     opcode,
    input  wire  [ADDR_W-1:0]   address,
    input  wire  [CNT_W-1:0]    sector_number,
    input  wire  [ADDR_W-1:0]   byte_size,
    input  wire                 m_tready,
    output logic                out_valid,
    output logic [ANS_W-1:0]    answer,
    output logic                valid_res
);

    // query registers
    op_t                  op_reg,    op_next;
    logic [KB_W-1:0]      kb_reg,    kb_next;
    logic                 lowok_reg, lowok_next;
    logic [CNT_W-1:0]     j_reg,     j_next;
    logic [CNT_W-1:0]     first_reg, first_next;
    logic [RK_W-1:0]      rk_reg,    rk_next;
    logic [IDX_W-1:0]     cnt_reg,   cnt_next;
    logic [KB_W-1:0]      acc_reg,   acc_next;
    logic [REG_IDX_W-1:0] r_reg,     r_next;
    logic                 fail_reg,  fail_next;
    logic [SIZE_W-1:0]    rem_reg,   rem_next;
    logic [QUO_W-1:0]     dq_reg,    dq_next;

    // output word
    logic                 out_valid_reg, out_valid_next;
    logic [ANS_W-1:0]     answer_reg,    answer_next;
    logic                 valid_res_reg, valid_res_next;

    logic [ADDR_W-1:0]    offset;
    logic [CNT_W-1:0]     n;
    logic [SIZE_W-1:0]    sz;
    logic                 kb_walk;
    logic                 in_region;
    logic [CNT_W-1:0]     m;
    logic [CNT_W-1:0]     mul_a;
    logic [SPAN_W-1:0]    prod;
    logic [KB_W-1:0]      rest;
    logic [RK_W-1:0]      rk_less;
    logic [KB_W-1:0]      dividend;
    logic                 kb_hit;
    logic                 end_hit;
    logic                 last;
    logic                 walk_fail;
    logic                 walk_done;
    logic                 walk_div;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 ge;
    logic [IDX_W-1:0]     idx_sum;
    logic [SCALED_W-1:0]  scaled;
    logic [ANS_W-1:0]     res_ans;
    logic                 res_vr;
    logic                 addr_load;

    assign offset = address - cfg.base;

    // current region and its span
    assign n         = cfg.region[r_reg][CNT_W-1:0];
    assign sz        = cfg.region[r_reg][REGION_W-1:CNT_W];
    assign kb_walk   = (op_reg == OP_ADDR) || (op_reg == OP_START);
    assign in_region = (j_reg < n);
    assign m         = n - j_reg;
    assign mul_a     = kb_walk ? n : m;
    assign prod      = SPAN_W'(mul_a) * SPAN_W'(sz);
    assign rest      = kb_reg - acc_reg;
    assign rk_less   = rk_reg - 1'b1;
    assign dividend  = kb_walk ? rest : rk_less[KB_W-1:0];
    assign kb_hit    = (prod > SPAN_W'(rest));
    assign end_hit   = (prod >= SPAN_W'(rk_reg));
    assign last      = (r_reg == LAST_REGION);

    // outcome of one region step
    always_comb
    begin
        walk_fail = 1'b0;
        walk_done = 1'b0;
        walk_div  = 1'b0;
        priority if ((op_reg == OP_END) && (rk_reg == '0))
            walk_fail = 1'b1;
        else if (n == '0)
            walk_fail = 1'b1;
        else if (kb_walk)
        begin
            if (kb_hit)
                walk_div = 1'b1;
            else
                walk_fail = last;
        end
        else if (in_region)
        begin
            priority if (op_reg == OP_SIZE)
                walk_done = 1'b1;
            else if (end_hit)
                walk_div = 1'b1;
            else
                walk_fail = last;
        end
        else
            walk_fail = last;
    end

    assign status.walk_stop = walk_fail || walk_done;
    assign status.walk_div  = walk_div;
    assign status.out_free  = !out_valid_reg || m_tready;

    // one quotient bit per divide step
    assign trial = {rem_reg, dq_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, sz};
    assign ge    = (trial >= {1'b0, sz});

    // query register updates
    always_comb
    begin
        op_next    = op_reg;
        kb_next    = kb_reg;
        lowok_next = lowok_reg;
        j_next     = j_reg;
        first_next = first_reg;
        rk_next    = rk_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        r_next     = r_reg;
        fail_next  = fail_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        priority if (cmd.start)
        begin
            op_next    = op_t'(opcode);
            kb_next    = offset[ADDR_W-1:KB_SHIFT];
            lowok_next = (address >= cfg.base) && (offset[KB_SHIFT-1:0] == '0);
            j_next     = sector_number;
            first_next = sector_number;
            rk_next    = RK_W'(byte_size[ADDR_W-1:KB_SHIFT])
                       + RK_W'(|byte_size[KB_SHIFT-1:0]);
            cnt_next   = '0;
            acc_next   = '0;
            r_next     = '0;
            fail_next  = 1'b0;
        end
        else if (cmd.walk)
        begin
            priority if (walk_fail)
                fail_next = 1'b1;
            else if (walk_done)
                rem_next = sz;
            else if (walk_div)
            begin
                rem_next = SIZE_W'(dividend[KB_W-1:QUO_W]);
                dq_next  = dividend[QUO_W-1:0];
            end
            else if (kb_walk)
            begin
                acc_next = acc_reg + KB_W'(prod);
                cnt_next = cnt_reg + IDX_W'(n);
                r_next   = r_reg + 1'b1;
            end
            else if (in_region)
            begin
                rk_next  = rk_reg - RK_W'(prod);
                cnt_next = cnt_reg + IDX_W'(m);
                j_next   = '0;
                r_next   = r_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg - n;
                r_next = r_reg + 1'b1;
            end
        end
        else if (cmd.div_step)
        begin
            rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            dq_next  = {dq_reg[QUO_W-2:0], ge};
        end
        else
        begin
            op_next = op_reg;
        end
    end

    // result forming
    assign idx_sum = IDX_W'((op_reg == OP_ADDR) ? cfg.first_index : first_reg)
                   + cnt_reg + IDX_W'(dq_reg);
    assign scaled  = SCALED_W'(idx_sum) * SCALED_W'(cfg.scale);

    always_comb
    begin
        unique case (op_reg)
            OP_ADDR:
            begin
                res_ans = fail_reg ? '0 : ANS_W'(scaled);
                res_vr  = !fail_reg;
            end
            OP_SIZE:
            begin
                res_ans = fail_reg ? '0 : ANS_W'(rem_reg);
                res_vr  = !fail_reg;
            end
            OP_START:
            begin
                res_ans = ANS_W'(!fail_reg && lowok_reg && (rem_reg == '0));
                res_vr  = 1'b1;
            end
            OP_END:
            begin
                res_ans = fail_reg ? '0 : ANS_W'(idx_sum);
                res_vr  = !fail_reg;
            end
            default:
            begin
                res_ans = '0;
                res_vr  = 1'b0;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        answer_next    = answer_reg;
        valid_res_next = valid_res_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            answer_next    = res_ans;
            valid_res_next = res_vr;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign valid_res = valid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        kb_reg        <= kb_next;
        lowok_reg     <= lowok_next;
        j_reg         <= j_next;
        first_reg     <= first_next;
        rk_reg        <= rk_next;
        cnt_reg       <= cnt_next;
        acc_reg       <= acc_next;
        r_reg         <= r_next;
        fail_reg      <= fail_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        answer_reg    <= answer_next;
        valid_res_reg <= valid_res_next;
    end

    // result load of a found address
    assign addr_load = cmd.load_out && (op_reg == OP_ADDR) && !fail_reg;

    // the offset walk never passes the queried offset
    `FSMAP_ASSERT(a_acc_le_kb, clk, rst_n, cmd.walk && kb_walk |-> (acc_reg <= kb_reg))

    // a found address leaves a remainder below the sector size
    `FSMAP_ASSERT(a_rem_lt_size, clk, rst_n, addr_load |-> (rem_reg < sz))

endmodule

`default_nettype wire

// ----- src/flash_sector_mapper.sv -----
// flash sector mapper top level: config registers, sequencer and datapath
// flow: accepted word, one region per walk cycle (up to 4), then for address, start and end
//   queries a radix-2 divide for an 8-bit quotient, then the result word, held while the output is full
// one query at a time through the region walk and the shared radix-2 divider; a new word is taken
//   as soon as the previous result is registered
// reset: asynchronous, clears the sequencer and output valid, loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module flash_sector_mapper
    import fsmap_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    // query words
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [S_TDATA_W-1:0] s_tdata,   // address[31:0], sector_number[39:32], byte_size[71:40]
    input  wire  [OP_W-1:0]      s_tuser,   // opcode[1:0]
    // result words
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // answer[31:0]
    output logic                 m_tuser,   // valid_res[0]
    // register port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [PADDR_W-1:0]   paddr,
    input  wire  [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // register file
    fsmap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    fsmap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    fsmap_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .opcode        (s_tuser),
        .address       (s_tdata[31:0]),
        .sector_number (s_tdata[39:32]),
        .byte_size     (s_tdata[71:40]),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .answer        (m_tdata),
        .valid_res     (m_tuser)
    );

endmodule

`default_nettype wire

// ----- test/tb_flash_sector_mapper.sv -----
// self-checking testbench for the flash sector mapper: query stream, register port, answer check
`timescale 1ns / 1ps

module tb_flash_sector_mapper
    import fsmap_pkg::*;
();

    localparam int IDLE_LIMIT = 4000;

    // tracks the region map and the answers still owed by the block
    class sector_answer_tracker;
        cfg_t        map;
        logic [31:0] answers_due[$];
        logic        valid_due[$];
        int          mismatches;

        function new();
            map.region[0]   = 24'd4100;
            map.region[1]   = 24'd16385;
            map.region[2]   = 24'd32775;
            map.region[3]   = 24'd0;
            map.base        = 32'h0800_0000;
            map.first_index = 8'd0;
            map.scale       = 5'd1;
            mismatches      = 0;
        endfunction

        function logic [7:0] count_of(int r);
            return map.region[r][7:0];
        endfunction

        function logic [15:0] kb_of(int r);
            return map.region[r][23:8];
        endfunction

        // total sectors before the first empty region
        function int table_sectors();
            int total;
            total = 0;
            for (int r = 0; r < LIVE_REGIONS; r++) begin
                if (count_of(r) == 0)
                    break;
                total += count_of(r);
            end
            return total;
        endfunction

        // byte offset of sector k from the base; past the table gives the flash size
        function logic [63:0] sector_start(int k);
            logic [63:0] off;
            logic [63:0] bytes;
            off = '0;
            for (int r = 0; r < LIVE_REGIONS; r++) begin
                if (count_of(r) == 0)
                    break;
                bytes = 64'(kb_of(r)) << 10;
                if (k < count_of(r))
                    return off + 64'(k) * bytes;
                off += 64'(count_of(r)) * bytes;
                k   -= count_of(r);
            end
            return off;
        endfunction

        // size in KB of one sector
        function bit sector_kb(input logic [31:0] sector, output logic [31:0] kb);
            logic [31:0] rest;
            rest = sector;
            kb   = '0;
            for (int r = 0; r < LIVE_REGIONS; r++) begin
                if (count_of(r) == 0)
                    return 1'b0;
                if (rest < 32'(count_of(r))) begin
                    kb = 32'(kb_of(r));
                    return 1'b1;
                end
                rest -= 32'(count_of(r));
            end
            return 1'b0;
        endfunction

        // offset and scaled sector index of an address
        function bit address_index(input logic [31:0] addr, output logic [31:0] ans);
            logic [31:0] offset;
            logic [63:0] kb, acc, idx, span, rest;
            offset = addr - map.base;
            kb     = 64'(offset >> 10);
            acc    = '0;
            idx    = 64'(map.first_index);
            ans    = '0;
            for (int r = 0; r < LIVE_REGIONS; r++) begin
                if (count_of(r) == 0)
                    return 1'b0;
                span = 64'(count_of(r)) * 64'(kb_of(r));
                rest = kb - acc;
                if (span > rest) begin
                    idx += rest / 64'(kb_of(r));
                    ans  = 32'(idx * 64'(map.scale));
                    return 1'b1;
                end
                idx += 64'(count_of(r));
                acc += span;
            end
            return 1'b0;
        endfunction

        // first byte of a nonzero sector, no wrap past the top of the address space
        function bit starts_sector(input logic [31:0] addr);
            logic [63:0] start, bytes, span, a;
            start = 64'(map.base);
            a     = 64'(addr);
            for (int r = 0; r < LIVE_REGIONS; r++) begin
                if (count_of(r) == 0)
                    return 1'b0;
                bytes = 64'(kb_of(r)) << 10;
                span  = 64'(count_of(r)) * bytes;
                if (bytes != 0 && a >= start && a < start + span && (a - start) % bytes == 0)
                    return 1'b1;
                start += span;
            end
            return 1'b0;
        endfunction

        // last sector touched by an image starting at a given sector
        function bit last_sector(input logic [31:0] image_bytes, input logic [7:0] first,
                                 output logic [31:0] ans);
            logic [63:0] acc;
            logic [31:0] sector, kb;
            acc    = '0;
            sector = 32'(first);
            ans    = '0;
            if (image_bytes == 0)
                return 1'b0;
            while (acc < 64'(image_bytes)) begin
                if (!sector_kb(sector, kb))
                    return 1'b0;
                acc += 64'(kb) << 10;
                sector++;
            end
            ans = sector - 1;
            return 1'b1;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // accepted query word: work out its answer
        function void note_query(op_t op, logic [31:0] addr, logic [7:0] sec,
                                 logic [31:0] image_bytes);
            logic [31:0] ans;
            bit          ok;
            ans = '0;
            case (op)
                OP_ADDR:  ok = address_index(addr, ans);
                OP_SIZE:  ok = sector_kb(32'(sec), ans);
                OP_START:
                begin
                    ans = 32'(starts_sector(addr));
                    ok  = 1'b1;
                end
                default:  ok = last_sector(image_bytes, sec, ans);
            endcase
            if (!ok)
                ans = '0;
            answers_due.push_back(ans);
            valid_due.push_back(ok);
        endfunction

        // accepted result word: compare with the oldest owed answer
        function void check_answer(logic [31:0] ans, logic vld);
            logic [31:0] exp_ans;
            logic        exp_vld;
            if (answers_due.size() == 0) begin
                $error("result word with no query outstanding: answer %0d, valid_res %0d",
                       ans, vld);
                mismatches++;
                return;
            end
            exp_ans = answers_due.pop_front();
            exp_vld = valid_due.pop_front();
            if (ans !== exp_ans) begin
                $error("answer mismatch: expected %0d, actual %0d", exp_ans, ans);
                mismatches++;
            end
            if (vld !== exp_vld) begin
                $error("valid_res mismatch: expected %0d, actual %0d", exp_vld, vld);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // address[31:0], sector_number[39:32], byte_size[71:40]
    logic [OP_W-1:0]      s_tuser;   // opcode[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // answer[31:0]
    logic                 m_tuser;   // valid_res[0]
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    sector_answer_tracker sb;
    bit                   calm;

    flash_sector_mapper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // result side back-pressure
    initial
    begin : result_sink
        int hold;
        bit ready_now;
        hold      = 0;
        ready_now = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold == 0) begin
                if (ready_now && !calm) begin
                    ready_now = 1'b0;
                    hold      = 1 + idle_len();
                end
                else begin
                    ready_now = 1'b1;
                    hold      = $urandom_range(1, 24);
                end
                m_tready <= ready_now;
            end
            hold--;
        end
    end

    // handshakes are sampled mid-cycle, where every signal has settled for the next edge
    always @(negedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_query(op_t'(s_tuser), s_tdata[31:0], s_tdata[39:32], s_tdata[71:40]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_answer(m_tdata, m_tuser);
    end

    // watchdog on cycles with no word moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(negedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one query word, held until taken
    task automatic send_query(input op_t op, input logic [31:0] addr, input logic [7:0] sec,
                              input logic [31:0] image_bytes);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {image_bytes, sec, addr};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // mostly in-range queries, some at sector edges, some noise
    task automatic send_random_query();
        op_t         op;
        logic [31:0] addr, image_bytes, base;
        logic [7:0]  sec;
        logic [63:0] span, lim;
        int          nsec, delta;
        base  = sb.map.base;
        span  = sb.sector_start(sb.table_sectors());
        nsec  = sb.table_sectors();
        op    = op_t'($urandom_range(0, 3));
        delta = $urandom_range(0, 3);
        delta = (delta == 0) ? -1 : (delta == 1) ? 1 : 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: addr = (span != 0) ? base + 32'(rand64() % span) : $urandom();
            6, 7:    addr = base + 32'(sb.sector_start($urandom_range(0, nsec))) + delta;
            8:       addr = $urandom_range(0, 1) ? base + 32'(span) + $urandom_range(0, 2047)
                                                 : base - $urandom_range(1, 2048);
            default: addr = $urandom();
        endcase
        if ($urandom_range(0, 9) < 8 && nsec < 255)
            sec = 8'($urandom_range(0, nsec + 1));
        else
            sec = 8'($urandom_range(0, 255));
        lim = (span > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: image_bytes = (lim != 0) ? 32'(1 + rand64() % lim) : $urandom();
            6:       image_bytes = 32'(sb.sector_start(sec + $urandom_range(1, 4))
                                       - sb.sector_start(sec)) + delta;
            7:       image_bytes = '0;
            8:       image_bytes = $urandom();
            default: image_bytes = $urandom_range(1, 4096);
        endcase
        send_query(op, addr, sec, image_bytes);
    endtask

    // register writes, each with a setup and an access phase
    task automatic write_map(input cfg_t m);
        logic [31:0] word [REG_SCALE + 1];
        for (int r = 0; r < REGION_REGS; r++)
            word[r] = 32'(m.region[r]);
        word[REG_BASE]  = m.base;
        word[REG_FIRST] = 32'(m.first_index);
        word[REG_SCALE] = 32'(m.scale);
        for (int i = 0; i <= REG_SCALE; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {RIDX_W'(i), 2'b00};
            pwdata  <= word[i];
            @(posedge clk);
            penable <= 1'b1;
            @(negedge clk);
            while (!pready)
                @(negedge clk);
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.map = m;
    endtask

    // stop sending and wait for every owed answer
    task automatic drain_results(input int tail);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // random region map
    function automatic cfg_t random_map();
        cfg_t        m;
        logic [7:0]  cnt;
        logic [15:0] kb;
        int          pick;
        for (int r = 0; r < REGION_REGS; r++) begin
            pick = $urandom_range(0, 9);
            cnt  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 8));
            case ($urandom_range(0, 9))
                0:       kb = 16'd0;
                1:       kb = 16'hFFFF;
                2, 3:    kb = 16'd1 << $urandom_range(0, 8);
                4:       kb = 16'($urandom_range(0, 16'hFFFF));
                default: kb = 16'($urandom_range(1, 512));
            endcase
            m.region[r] = {kb, cnt};
        end
        case ($urandom_range(0, 4))
            0:       m.base = 32'h0000_0000;
            1:       m.base = 32'hFFFF_FFFF;
            2:       m.base = 32'hFFFF_FFFF - ($urandom_range(0, 32'h10_0000) & ~32'h3FF);
            3:       m.base = $urandom() & ~32'h3FF;
            default: m.base = $urandom();
        endcase
        m.first_index = 8'($urandom_range(0, 255));
        m.scale       = 5'($urandom_range(1, 16));
        return m;
    endfunction

    // main sequence
    initial
    begin : stimulus
        cfg_t        m;
        cfg_t        boot_map;
        logic [31:0] b;
        sb       = new();
        boot_map = sb.map;
        calm     = 1'b0;
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ADDR;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed queries on the map loaded at reset
        b = sb.map.base;
        send_query(OP_ADDR, b, 8'd0, 32'd0);
        send_query(OP_ADDR, b + 32'h3FFF, 8'd0, 32'd0);
        send_query(OP_ADDR, b + 32'h4000, 8'd0, 32'd0);
        send_query(OP_ADDR, b + 32'h2_0000, 8'd0, 32'd0);
        send_query(OP_ADDR, b + 32'hF_FFFF, 8'd0, 32'd0);
        // past the end, below the base, extremes of the address
        send_query(OP_ADDR, b + 32'h10_0000, 8'd0, 32'd0);
        send_query(OP_ADDR, b - 32'd1, 8'd0, 32'd0);
        send_query(OP_ADDR, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_query(OP_ADDR, 32'd0, 8'd0, 32'd0);
        send_query(OP_SIZE, 32'd0, 8'd0, 32'd0);
        send_query(OP_SIZE, 32'd0, 8'd4, 32'd0);
        send_query(OP_SIZE, 32'd0, 8'd11, 32'd0);
        send_query(OP_SIZE, 32'd0, 8'd12, 32'd0);
        send_query(OP_SIZE, 32'd0, 8'd255, 32'd0);
        // sector start: base counts, end of flash does not
        send_query(OP_START, b, 8'd0, 32'd0);
        send_query(OP_START, b + 32'h1_0000, 8'd0, 32'd0);
        send_query(OP_START, b + 32'h4001, 8'd0, 32'd0);
        send_query(OP_START, b + 32'h10_0000, 8'd0, 32'd0);
        send_query(OP_START, b - 32'h4000, 8'd0, 32'd0);
        // image end: empty image, exact fits, overruns
        send_query(OP_END, 32'd0, 8'd0, 32'd0);
        send_query(OP_END, 32'd0, 8'd0, 32'h4000);
        send_query(OP_END, 32'd0, 8'd0, 32'h4001);
        send_query(OP_END, 32'd0, 8'd0, 32'h10_0000);
        send_query(OP_END, 32'd0, 8'd0, 32'hFFFF_FFFF);
        send_query(OP_END, 32'd0, 8'd255, 32'd1);
        repeat (60) send_random_query();

        // one region map per phase, written while the block is idle
        for (int phase = 0; phase < 10; phase++) begin
            drain_results(4);
            case (phase)
                0:
                begin
                    // widest counts and sizes, top of index range and scale
                    m.region[0]   = {16'd1, 8'd255};
                    m.region[1]   = {16'hFFFF, 8'd255};
                    m.region[2]   = {16'd0, 8'd3};
                    m.region[3]   = {16'd4, 8'd2};
                    m.base        = 32'h0000_0000;
                    m.first_index = 8'd255;
                    m.scale       = 5'd16;
                end
                1:
                begin
                    // empty table
                    m             = random_map();
                    m.region[0]   = {16'($urandom_range(0, 16'hFFFF)), 8'd0};
                    m.base        = 32'hFFFF_FFFF;
                    m.first_index = 8'd0;
                    m.scale       = 5'd1;
                end
                2:
                begin
                    // zero-size sectors ahead of and between real ones
                    m             = random_map();
                    m.region[0]   = {16'd0, 8'd5};
                    m.region[1]   = {16'd4, 8'd3};
                    m.region[2]   = {16'd0, 8'd2};
                    m.region[3]   = {16'd8, 8'd255};
                end
                9:       m = boot_map;
                default: m = random_map();
            endcase
            write_map(m);
            calm = ($urandom_range(0, 3) == 0);
            repeat ((phase == 1) ? 15 : 60) send_random_query();
        end

        drain_results(20);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- flash_sector_mapper.f -----
+incdir+src
src/fsmap_pkg.sv
src/fsmap_regs.sv
src/fsmap_ctrl.sv
src/fsmap_dp.sv
src/flash_sector_mapper.sv
test/tb_flash_sector_mapper.sv
